FILE: src/adgv_pkg.sv
// adgv_pkg: shared types, constants and helper functions for the genetic
// value accumulator. No dependencies.
package adgv_pkg;

  localparam int MAX_INDIVIDUALS = 1024;
  localparam int IDX_W = $clog2(MAX_INDIVIDUALS);
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLOIDY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOM_EN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GXE_EN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_INT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GXE_INT = 3'd4;

  localparam logic signed [49:0] ACC_MAX = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [49:0] ACC_MIN = 50'sh3_8000_0000_0000;
  localparam logic signed [57:0] RND_HALF = 58'sd8388608;

  // round(2^24/p) and round(2^24/p^2)
  localparam logic [24:0] RECIP_P [0:8] = '{
    25'd0, 25'd16777216, 25'd8388608, 25'd5592405, 25'd4194304,
    25'd3355443, 25'd2796203, 25'd2396745, 25'd2097152
  };
  localparam logic [24:0] RECIP_P2 [0:8] = '{
    25'd0, 25'd16777216, 25'd4194304, 25'd1864135, 25'd1048576,
    25'd671089, 25'd466034, 25'd342392, 25'd262144
  };

  typedef struct packed {
    logic [IDX_W-1:0]    individual;
    logic [3:0]          dosage;
    logic signed [31:0]  additive_effect;
    logic signed [31:0]  dominance_effect;
    logic signed [31:0]  environment_effect;
    logic                last_locus;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]    result_individual;
    logic signed [47:0]  genetic_value;
    logic signed [47:0]  gxe_value;
    logic                saturated;
  } out_item_t;

  typedef struct packed {
    logic [3:0]          ploidy_level;
    logic                dominance_enable;
    logic                gxe_enable;
    logic signed [31:0]  base_intercept;
    logic signed [31:0]  gxe_intercept;
  } cfg_t;

  typedef struct packed {
    logic signed [25:0]  a;
    logic signed [25:0]  d;
  } coef_t;

  typedef struct packed {
    logic [IDX_W-1:0]    individual;
    logic signed [25:0]  coef_a;
    logic signed [25:0]  coef_d;
    logic signed [31:0]  additive_effect;
    logic signed [31:0]  dominance_effect;
    logic signed [31:0]  environment_effect;
    logic                last_locus;
  } work_t;

  typedef struct packed {
    logic push;
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic signed [47:0]  val;
    logic signed [47:0]  gxe;
    logic                mark;
  } entry_t;

  typedef struct packed {
    logic                flag;
    logic signed [47:0]  value;
  } sat_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_MUL, ST_RND, ST_ACC, ST_REP
  } st_t;

  function automatic sat_t sat48(input logic signed [49:0] s);
    sat_t r;
    if (s > ACC_MAX) begin
      r.flag = 1'b1;
      r.value = ACC_MAX[47:0];
    end else if (s < ACC_MIN) begin
      r.flag = 1'b1;
      r.value = ACC_MIN[47:0];
    end else begin
      r.flag = 1'b0;
      r.value = s[47:0];
    end
    return r;
  endfunction

  // (2x-p)*RA[p] and 4x(p-x)*RD[p] with p and x clamped
  function automatic coef_t coef_of(input logic [3:0] ploidy, input logic [3:0] dosage);
    logic [3:0]        p;
    logic [3:0]        x;
    logic signed [5:0] k;
    logic [4:0]        xm;
    logic [6:0]        kd;
    coef_t             c;
    p = (ploidy == 4'd0) ? 4'd1 : ((ploidy > 4'd8) ? 4'd8 : ploidy);
    x = (dosage > p) ? p : dosage;
    k = $signed({1'b0, x, 1'b0}) - $signed({2'b00, p});
    xm = 5'(5'(x) * 5'(p - x));
    kd = {xm, 2'b00};
    c.a = 26'(k * $signed({1'b0, RECIP_P[p]}));
    c.d = $signed(26'({1'b0, kd} * RECIP_P2[p]));
    return c;
  endfunction

endpackage

FILE: src/adgv_if.sv
// adgv_if: valid/ready channel interfaces for input items and results.
// Depends on adgv_pkg.
interface adgv_item_if;
  import adgv_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface adgv_result_if;
  import adgv_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/adgv_front.sv
// adgv_front: accepts input items, clamps ploidy and dosage and turns them
// into locus coefficients for the queue. Depends on adgv_pkg, adgv_if.
module adgv_front (
  adgv_item_if.sink            item,
  input  logic [3:0]           ploidy_level,
  input  logic                 clearing,
  input  adgv_pkg::q_stat_t    q_in,
  output logic                 push,
  output adgv_pkg::work_t      work
);
  import adgv_pkg::*;

  coef_t coef;

  assign item.ready = !q_in.full && !clearing;
  assign push = item.valid && item.ready;
  assign coef = coef_of(ploidy_level, item.data.dosage);

  always_comb begin
    work.individual = item.data.individual;
    work.coef_a = coef.a;
    work.coef_d = coef.d;
    work.additive_effect = item.data.additive_effect;
    work.dominance_effect = item.data.dominance_effect;
    work.environment_effect = item.data.environment_effect;
    work.last_locus = item.data.last_locus;
  end

endmodule

FILE: src/adgv_queue.sv
// adgv_queue: short fifo of classified work between front and back.
// Depends on adgv_pkg.
module adgv_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  adgv_pkg::work_t   wdata,
  input  logic              pop,
  output adgv_pkg::work_t   head,
  output adgv_pkg::q_stat_t stat
);
  import adgv_pkg::*;

  work_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= QPTR_W'(wr_ptr + 1'b1);
      if (pop) rd_ptr <= QPTR_W'(rd_ptr + 1'b1);
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wdata;
  end

  assign head = slots[rd_ptr];

  always_comb begin
    stat.push = push;
    stat.full = (count == (QPTR_W+1)'(QDEPTH));
    stat.empty = (count == '0);
  end

endmodule

FILE: src/adgv_back.sv
// adgv_back: per-individual stores and the read-modify-write sequencer that
// applies locus terms and reports totals. Depends on adgv_pkg, adgv_if.
module adgv_back (
  input  logic              clk,
  input  logic              rst,
  input  adgv_pkg::cfg_t    cfg,
  input  adgv_pkg::q_stat_t q_in,
  input  adgv_pkg::work_t   head,
  output logic              pop,
  output logic              clearing,
  adgv_result_if.source     result
);
  import adgv_pkg::*;

  st_t state;
  st_t state_next;

  entry_t mem [MAX_INDIVIDUALS];
  entry_t rd_q;
  logic             mem_we;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic [IDX_W-1:0] clr_cnt;

  work_t              w;
  logic signed [57:0] prod_a;
  logic signed [57:0] prod_d;
  logic signed [57:0] prod_g;
  logic signed [57:0] sum_a;
  logic signed [57:0] sum_d;
  logic signed [57:0] sum_g;
  logic signed [33:0] rnd_d;
  logic signed [34:0] rnd_v;
  logic signed [33:0] rnd_g;
  logic signed [47:0] acc_v;
  logic signed [47:0] acc_g;
  logic               flag;
  sat_t               sv_acc;
  sat_t               sg_acc;
  sat_t               sv_rep;
  sat_t               sg_rep;
  logic signed [47:0] new_g;
  logic               new_flag;
  logic               out_free;
  logic               res_valid;
  out_item_t          res;

  assign out_free = !res_valid || result.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == IDX_W'(MAX_INDIVIDUALS - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (!q_in.empty) state_next = ST_MUL;
      ST_MUL:   state_next = ST_RND;
      ST_RND:   state_next = ST_ACC;
      ST_ACC:   state_next = w.last_locus ? ST_REP : ST_IDLE;
      ST_REP:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    clearing = 1'b0;
    mem_we = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        clearing = 1'b1;
        mem_we = 1'b1;
      end
      ST_IDLE:  pop = !q_in.empty;
      ST_ACC:   mem_we = !w.last_locus;
      ST_REP:   mem_we = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (state == ST_CLEAR) clr_cnt <= IDX_W'(clr_cnt + 1'b1);
  end

  // store datapath
  assign wr_addr = (state == ST_CLEAR) ? clr_cnt : w.individual;
  always_comb begin
    wr_data = '0;
    if (state == ST_ACC) begin
      wr_data.val = sv_acc.value;
      wr_data.gxe = new_g;
      wr_data.mark = new_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (pop) rd_q <= mem[head.individual];
  end

  // term arithmetic
  assign sum_a = prod_a + RND_HALF;
  assign sum_d = prod_d + RND_HALF;
  assign sum_g = prod_g + RND_HALF;
  assign rnd_d = cfg.dominance_enable ? $signed(sum_d[57:24]) : 34'sd0;

  assign sv_acc = sat48(50'(rd_q.val) + 50'(rnd_v));
  assign sg_acc = sat48(50'(rd_q.gxe) + 50'(rnd_g));
  assign new_g = cfg.gxe_enable ? sg_acc.value : rd_q.gxe;
  assign new_flag = rd_q.mark || sv_acc.flag || (cfg.gxe_enable && sg_acc.flag);

  assign sv_rep = sat48(50'(cfg.base_intercept) + 50'(acc_v));
  assign sg_rep = sat48(50'(cfg.gxe_intercept) + 50'(acc_g));

  always_ff @(posedge clk) begin
    if (pop) w <= head;
    if (state == ST_MUL) begin
      prod_a <= w.additive_effect * w.coef_a;
      prod_d <= w.dominance_effect * w.coef_d;
      prod_g <= w.environment_effect * w.coef_a;
    end
    if (state == ST_RND) begin
      rnd_v <= 35'($signed(sum_a[57:24])) + 35'(rnd_d);
      rnd_g <= $signed(sum_g[57:24]);
    end
    if (state == ST_ACC) begin
      acc_v <= sv_acc.value;
      acc_g <= new_g;
      flag <= new_flag;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (state == ST_REP && out_free) res_valid <= 1'b1;
    else if (result.ready) res_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (state == ST_REP && out_free) begin
      res.result_individual <= w.individual;
      res.genetic_value <= sv_rep.value;
      res.gxe_value <= cfg.gxe_enable ? sg_rep.value : 48'sd0;
      res.saturated <= flag || sv_rep.flag || (cfg.gxe_enable && sg_rep.flag);
    end
  end

  assign result.valid = res_valid;
  assign result.data = res;

`ifndef SYNTHESIS
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !pop)
    else $error("queue popped during store clear");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_in.empty)
    else $error("pop from empty queue");
  a_res_from_rep: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == ST_REP))
    else $error("result raised outside report step");
  a_rep_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REP && out_free) |=> (res_valid && state == ST_IDLE))
    else $error("report step did not load result");
`endif

endmodule

FILE: src/additive_dominance_genetic_value.sv
// additive_dominance_genetic_value: top level with configuration registers,
// front, queue and back. Depends on adgv_pkg, adgv_if, adgv_front,
// adgv_queue, adgv_back.
//
// After reset the block zeroes its per-individual stores and takes no item
// meanwhile; configuration writes are taken at any time. Each item then has
// the back end alone, a last locus also its report state: the store is a
// single-port read-modify-write memory, and the sequencer reads the entry,
// multiplies, rounds and writes back before the next item may touch
// the same individual. A two-entry queue lets the input run ahead of that
// loop, and a result register holds the report until taken.
module additive_dominance_genetic_value (
  input  logic                           clk,
  input  logic                           rst,
  adgv_item_if.sink                      item,
  adgv_result_if.source                  result,
  input  logic                           cfg_we,
  input  logic [adgv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);
  import adgv_pkg::*;

  cfg_t    cfg;
  q_stat_t q_stat;
  q_stat_t q_front;
  work_t   work;
  work_t   head;
  logic    push;
  logic    pop;
  logic    clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ploidy_level <= 4'd2;
      cfg.dominance_enable <= 1'b0;
      cfg.gxe_enable <= 1'b0;
      cfg.base_intercept <= '0;
      cfg.gxe_intercept <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PLOIDY:   cfg.ploidy_level <= cfg_data[3:0];
        CFG_DOM_EN:   cfg.dominance_enable <= cfg_data[0];
        CFG_GXE_EN:   cfg.gxe_enable <= cfg_data[0];
        CFG_BASE_INT: cfg.base_intercept <= $signed(cfg_data);
        CFG_GXE_INT:  cfg.gxe_intercept <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    q_front = q_stat;
    q_front.push = push;
  end

  adgv_front u_front (
    .item         (item),
    .ploidy_level (cfg.ploidy_level),
    .clearing     (clearing),
    .q_in         (q_front),
    .push         (push),
    .work         (work)
  );

  adgv_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (work),
    .pop   (pop),
    .head  (head),
    .stat  (q_stat)
  );

  adgv_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_in     (q_stat),
    .head     (head),
    .pop      (pop),
    .clearing (clearing),
    .result   (result)
  );

endmodule

FILE: tb/sv/adgv_value_check.sv
// adgv_value_check: watches the locus and report channels and the register
// port, predicts each report of the genetic value accumulator and compares it.
// Depends on adgv_pkg and adgv_if.
`timescale 1ns / 1ps

module adgv_value_check (
  input  logic                           clk,
  input  logic                           rst,
  adgv_item_if                           item,
  adgv_result_if                         result,
  input  logic                           cfg_we,
  input  logic [adgv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  output int                             errors,
  output int                             pending
);
  import adgv_pkg::*;

  localparam longint VALUE_TOP = 64'sd140737488355327;
  localparam longint VALUE_BOTTOM = -VALUE_TOP - 64'sd1;
  localparam longint HALF_LSB = 64'sd8388608;
  localparam longint RECIP_A [0:8] = '{
    0, 16777216, 8388608, 5592405, 4194304, 3355443, 2796203, 2396745, 2097152
  };
  localparam longint RECIP_D [0:8] = '{
    0, 16777216, 4194304, 1864135, 1048576, 671089, 466034, 342392, 262144
  };

  logic [3:0] ploidy;
  bit         dom_on;
  bit         gxe_on;
  longint     base_int;
  longint     gxe_int;

  longint     value_acc [MAX_INDIVIDUALS];
  longint     gxe_acc [MAX_INDIVIDUALS];
  bit         sat_mark [MAX_INDIVIDUALS];
  bit         clamp_seen;
  out_item_t  expected_reports [$];

  function automatic longint round_q16(input longint v);
    return (v + HALF_LSB) >>> 24;
  endfunction

  function automatic longint clamp48(input longint s);
    if (s > VALUE_TOP) begin
      clamp_seen = 1'b1;
      return VALUE_TOP;
    end
    if (s < VALUE_BOTTOM) begin
      clamp_seen = 1'b1;
      return VALUE_BOTTOM;
    end
    return s;
  endfunction

  function automatic void apply_locus(input in_item_t it);
    longint    p;
    longint    x;
    longint    k;
    longint    a;
    longint    d;
    longint    g;
    longint    contrib;
    longint    gv;
    longint    ge;
    int        ind;
    out_item_t rep;
    ind = it.individual;
    p = ploidy;
    if (p < 1) p = 1;
    if (p > 8) p = 8;
    x = it.dosage;
    if (x > p) x = p;
    a = $signed(it.additive_effect);
    d = $signed(it.dominance_effect);
    g = $signed(it.environment_effect);
    k = 2 * x - p;
    clamp_seen = sat_mark[ind];
    contrib = round_q16(a * k * RECIP_A[p]);
    if (dom_on) contrib += round_q16(d * (4 * x * (p - x)) * RECIP_D[p]);
    value_acc[ind] = clamp48(value_acc[ind] + contrib);
    if (gxe_on) gxe_acc[ind] = clamp48(gxe_acc[ind] + round_q16(g * k * RECIP_A[p]));
    if (!it.last_locus) begin
      sat_mark[ind] = clamp_seen;
      return;
    end
    gv = clamp48(base_int + value_acc[ind]);
    ge = 0;
    if (gxe_on) ge = clamp48(gxe_int + gxe_acc[ind]);
    rep.result_individual = it.individual;
    rep.genetic_value = gv[47:0];
    rep.gxe_value = ge[47:0];
    rep.saturated = clamp_seen;
    expected_reports.push_back(rep);
    value_acc[ind] = 0;
    gxe_acc[ind] = 0;
    sat_mark[ind] = 1'b0;
  endfunction

  function automatic void check_report(input out_item_t got);
    out_item_t want;
    if (expected_reports.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("report for individual %0d with none outstanding", got.result_individual);
      return;
    end
    want = expected_reports.pop_front();
    if (got.result_individual !== want.result_individual ||
        got.genetic_value !== want.genetic_value ||
        got.gxe_value !== want.gxe_value ||
        got.saturated !== want.saturated) begin
      errors++;
      if (errors <= 10)
        $display("report mismatch: expected ind %0d value %0d gxe %0d sat %0b,",
                 want.result_individual, $signed(want.genetic_value),
                 $signed(want.gxe_value), want.saturated,
                 " got ind %0d value %0d gxe %0d sat %0b",
                 got.result_individual, $signed(got.genetic_value),
                 $signed(got.gxe_value), got.saturated);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      ploidy = 4'd2;
      dom_on = 1'b0;
      gxe_on = 1'b0;
      base_int = 0;
      gxe_int = 0;
      foreach (value_acc[i]) begin
        value_acc[i] = 0;
        gxe_acc[i] = 0;
        sat_mark[i] = 1'b0;
      end
      expected_reports.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PLOIDY:   ploidy = cfg_data[3:0];
          CFG_DOM_EN:   dom_on = cfg_data[0];
          CFG_GXE_EN:   gxe_on = cfg_data[0];
          CFG_BASE_INT: base_int = $signed(cfg_data);
          CFG_GXE_INT:  gxe_int = $signed(cfg_data);
          default: ;
        endcase
      end
      // locus transfer first, a report can never belong to the same edge
      if (item.valid && item.ready) apply_locus(item.data);
      if (result.valid && result.ready) check_report(result.data);
      pending = expected_reports.size();
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// testbench: drives loci and register writes into the genetic value
// accumulator with random gaps and stalls; adgv_value_check judges the reports.
// Depends on adgv_pkg, adgv_if, adgv_value_check and the block itself.
`timescale 1ns / 1ps

module testbench;
  import adgv_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 32;
  localparam int SEGMENTS = 8;
  localparam int SEGMENT_LOCI = 210;
  localparam logic [31:0] EFF_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] EFF_MIN = 32'h8000_0000;
  localparam logic [31:0] EFF_NEG1 = 32'hFFFF_FFFF;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  int                   mismatches;
  int                   pending;
  bit                   quiet;
  int                   holds_asked;
  int                   holds_done;

  adgv_item_if   item ();
  adgv_result_if result ();

  additive_dominance_genetic_value dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  adgv_value_check value_check (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (mismatches),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("testbench: errors");
    $finish;
  end

  function automatic logic [31:0] pick_effect();
    case ($urandom_range(7))
      0: return EFF_MAX;
      1: return EFF_MIN;
      2: return 32'($urandom_range(131072)) - 32'd65536;
      default: return $urandom;
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_locus(input logic [IDX_W-1:0] ind, input logic [3:0] dos,
                            input logic [31:0] a, input logic [31:0] d,
                            input logic [31:0] g, input logic last);
    int gap;
    gap = quiet ? 0 : $urandom_range(6);
    if (gap > 0) begin
      item.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item.valid = 1'b1;
    item.data.individual = ind;
    item.data.dosage = dos;
    item.data.additive_effect = a;
    item.data.dominance_effect = d;
    item.data.environment_effect = g;
    item.data.last_locus = last;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [3:0] p, input logic dom, input logic gxe,
                            input logic [31:0] bi, input logic [31:0] gi);
    write_reg(CFG_PLOIDY, {28'd0, p});
    write_reg(CFG_DOM_EN, {31'd0, dom});
    write_reg(CFG_GXE_EN, {31'd0, gxe});
    write_reg(CFG_BASE_INT, bi);
    write_reg(CFG_GXE_INT, gi);
    cfg_we = 1'b0;
  endtask

  // wait for every report, then let loci without a report retire
  task automatic drain();
    item.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_config();
    logic [3:0] p;
    case ($urandom_range(5))
      0: p = 4'd1;
      1: p = 4'd8;
      2: p = 4'd0;
      3: p = 4'($urandom_range(9, 15));
      default: p = 4'($urandom_range(1, 8));
    endcase
    set_config(p, 1'($urandom), 1'($urandom), pick_effect(), pick_effect());
  endtask

  // mostly loci of a small group of individuals, some stray ones
  task automatic run_segment(input int count);
    logic [IDX_W-1:0] group [0:7];
    logic [IDX_W-1:0] ind;
    group[0] = '0;
    group[1] = '1;
    for (int i = 2; i < 8; i++) group[i] = IDX_W'($urandom);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9) == 0) ind = IDX_W'($urandom);
      else ind = group[$urandom_range(7)];
      send_locus(ind, 4'($urandom), pick_effect(), pick_effect(), pick_effect(),
                 $urandom_range(3) == 0);
    end
  endtask

  initial begin
    int stall;
    result.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (holds_done < holds_asked) begin
        result.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end else begin
        stall = quiet ? 0 : $urandom_range(6);
        if (stall > 0) begin
          result.ready = 1'b0;
          repeat (stall) @(negedge clk);
        end
        result.ready = 1'b1;
        @(posedge clk);
        while (!result.valid) @(posedge clk);
        @(negedge clk);
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_PLOIDY;
    cfg_data = '0;
    item.valid = 1'b0;
    item.data = '0;
    quiet = 1'b0;
    holds_asked = 0;
    holds_done = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings
    send_locus(10'd3, 4'd1, EFF_MAX, EFF_MAX, EFF_MAX, 1'b1);
    send_locus(10'd4, 4'd2, EFF_MIN, EFF_MIN, EFF_MIN, 1'b1);
    drain();

    set_config(4'd8, 1'b1, 1'b1, EFF_MAX, EFF_MIN);
    send_locus(10'd10, 4'd0, EFF_MAX, EFF_MAX, EFF_MAX, 1'b0);
    send_locus(10'd10, 4'd8, EFF_MIN, EFF_MIN, EFF_MIN, 1'b0);
    send_locus(10'd10, 4'd6, EFF_MAX, EFF_MIN, EFF_MAX, 1'b0);
    send_locus(10'd10, 4'd15, EFF_NEG1, EFF_NEG1, EFF_NEG1, 1'b1);
    send_locus(10'd1023, 4'd4, EFF_MIN, EFF_MAX, EFF_MIN, 1'b1);
    send_locus(10'd0, 4'd3, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 1'b1);
    drain();

    // ploidy zero acts as one
    set_config(4'd0, 1'b1, 1'b0, EFF_MIN, EFF_MAX);
    send_locus(10'd0, 4'd0, EFF_MAX, EFF_MAX, EFF_MAX, 1'b0);
    send_locus(10'd0, 4'd1, EFF_MIN, EFF_MAX, EFF_MAX, 1'b0);
    send_locus(10'd0, 4'd9, 32'h0000_0001, EFF_MIN, EFF_MIN, 1'b1);
    send_locus(10'd1, 4'd0, '0, '0, '0, 1'b1);
    drain();

    // ploidy above eight acts as eight
    set_config(4'd15, 1'b0, 1'b1, '0, '0);
    send_locus(10'd512, 4'd15, EFF_MAX, EFF_MAX, EFF_MIN, 1'b1);
    send_locus(10'd511, 4'd7, 32'h1234_5678, 32'h8765_4321, 32'hDEAD_BEEF, 1'b1);
    drain();

    set_config(4'd3, 1'b1, 1'b1, 32'h0000_8000, 32'hFFFF_8000);
    send_locus(10'd5, 4'd1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
    send_locus(10'd5, 4'd2, EFF_NEG1, 32'h0000_0001, 32'hFFFF_FFFE, 1'b0);
    send_locus(10'd5, 4'd3, 32'h7FFF_0000, 32'h8000_FFFF, 32'h0000_0003, 1'b1);
    drain();

    // report side held off while loci keep coming, input must back up
    set_config(4'd2, 1'b1, 1'b1, pick_effect(), pick_effect());
    holds_asked++;
    quiet = 1'b1;
    for (int n = 0; n < 40; n++)
      send_locus(IDX_W'($urandom), 4'($urandom), pick_effect(), pick_effect(),
                 pick_effect(), 1'b1);
    quiet = 1'b0;
    drain();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      random_config();
      quiet = (seg == 3);
      run_segment(SEGMENT_LOCI);
      quiet = 1'b0;
      drain();
    end

    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
